// File: hdl/ptw_pkg.sv
// Shared types, constants and operation codes for the policy tree walk engine.
`default_nettype none
package ptw_pkg;

  localparam int TREE_DEPTH     = 5;
  localparam int NUM_COVARIATES = 16;
  localparam int NUM_ACTIONS    = 16;

  localparam int NODE_COUNT   = (1 << (TREE_DEPTH + 1)) - 1;
  localparam int FIRST_BOTTOM = (1 << TREE_DEPTH) - 1;

  localparam int OP_W   = 3;
  localparam int NODE_W = 6;
  localparam int COV_W  = 4;
  localparam int VAL_W  = 32;
  localparam int ACT_W  = 4;
  localparam int REW_W  = 48;

  localparam logic signed [REW_W-1:0] REW_MAX = {1'b0, {(REW_W-1){1'b1}}};
  localparam logic signed [REW_W-1:0] REW_MIN = {1'b1, {(REW_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_SPLIT = 3'd0,
    OP_WRITE_LEAF  = 3'd1,
    OP_LOAD_COV    = 3'd2,
    OP_CLASSIFY    = 3'd3,
    OP_ACCUMULATE  = 3'd4,
    OP_READ_REWARD = 3'd5
  } op_t;

  typedef struct packed {
    logic                     is_split;
    logic [COV_W-1:0]         cov;
    logic signed [VAL_W-1:0]  thr;
    logic [ACT_W-1:0]         action;
    logic                     action_set;
    logic signed [REW_W-1:0]  reward;
  } node_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    node_t             data;
  } wr_req_t;

endpackage
`default_nettype wire

// File: hdl/policy_tree_walk_engine.sv
// Top level: command decode, tree walk sequencer, covariate registers and result register.
// Command-style block: a transaction is taken when start is high and busy is low, and its one
// result appears for a single cycle with out_valid high; the receiver cannot stall it. Loading
// a covariate, an out-of-range node address and the unused codes never raise busy. Writing a
// node is a read-modify-write of the node memory and reading a reward is a read of it. Classify
// and accumulate visit 1 to TREE_DEPTH+1 nodes (at most 6 here): each level is one registered
// read of the node memory, with the accumulated reward written back in the same cycle as the
// child is read. Node state and covariates are zero after reset with no clearing pass.
`default_nettype none
module policy_tree_walk_engine (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [ptw_pkg::OP_W-1:0]            in_operation,
  input  wire logic [ptw_pkg::NODE_W-1:0]          in_node_addr,
  input  wire logic [ptw_pkg::COV_W-1:0]           in_covariate_index,
  input  wire logic signed [ptw_pkg::VAL_W-1:0]    in_value,
  input  wire logic [ptw_pkg::ACT_W-1:0]           in_leaf_action,
  input  wire logic signed [ptw_pkg::REW_W-1:0]    in_reward_in,
  output logic                                     out_valid,
  output logic [ptw_pkg::ACT_W-1:0]                out_action_out,
  output logic                                     out_action_valid,
  output logic [ptw_pkg::NODE_W-1:0]               out_leaf_reached,
  output logic signed [ptw_pkg::REW_W-1:0]         out_reward_out,
  output logic                                     out_saturated
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MODIFY,
    ST_READ,
    ST_WALK
  } state_t;

  state_t                               state_r;
  ptw_pkg::op_t                         op_r;
  logic [ptw_pkg::NODE_W-1:0]           addr_r;
  logic [ptw_pkg::COV_W-1:0]            cidx_r;
  logic signed [ptw_pkg::VAL_W-1:0]     val_r;
  logic [ptw_pkg::ACT_W-1:0]            act_r;
  logic signed [ptw_pkg::REW_W-1:0]     rew_r;
  logic [ptw_pkg::NODE_W-1:0]           n_r;
  logic                                 sat_r;

  logic                                 out_valid_r;
  logic [ptw_pkg::ACT_W-1:0]            out_action_r;
  logic                                 out_action_valid_r;
  logic [ptw_pkg::NODE_W-1:0]           out_leaf_r;
  logic signed [ptw_pkg::REW_W-1:0]     out_reward_r;
  logic                                 out_sat_r;

  logic signed [ptw_pkg::VAL_W-1:0]     cov_r [ptw_pkg::NUM_COVARIATES];

  ptw_pkg::rd_req_t                     rd_req;
  ptw_pkg::wr_req_t                     wr_req;
  ptw_pkg::node_t                       node;

  logic                                 accept;
  ptw_pkg::op_t                         in_op;
  logic                                 in_addr_ok;
  logic                                 in_cidx_ok;
  logic                                 act_ok;
  logic                                 cov_ok;
  logic signed [ptw_pkg::VAL_W-1:0]     cov_sel;
  logic                                 go_left;
  logic [ptw_pkg::NODE_W-1:0]           child;
  logic                                 walk_done;
  logic signed [ptw_pkg::REW_W:0]       rew_sum;
  logic                                 clip;
  logic signed [ptw_pkg::REW_W-1:0]     rew_new;
  ptw_pkg::node_t                       mod_node;

  ptw_node_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_req  (rd_req),
    .wr_req  (wr_req),
    .rd_data (node)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign in_op  = ptw_pkg::op_t'(in_operation);

  assign in_addr_ok = (int'(in_node_addr) < ptw_pkg::NODE_COUNT);
  assign in_cidx_ok = (int'(in_covariate_index) < ptw_pkg::NUM_COVARIATES);
  assign act_ok     = (int'(act_r) < ptw_pkg::NUM_ACTIONS);

  // Split test: slots past the covariate vector compare as zero.
  assign cov_ok    = (int'(node.cov) < ptw_pkg::NUM_COVARIATES);
  assign cov_sel   = cov_ok ? cov_r[node.cov] : '0;
  assign go_left   = (cov_sel <= node.thr);
  assign child     = go_left ? ((n_r << 1) + ptw_pkg::NODE_W'(1))
                             : ((n_r << 1) + ptw_pkg::NODE_W'(2));
  assign walk_done = !node.is_split || (int'(n_r) >= ptw_pkg::FIRST_BOTTOM);

  assign rew_sum = {node.reward[ptw_pkg::REW_W-1], node.reward}
                 + {rew_r[ptw_pkg::REW_W-1], rew_r};
  assign clip    = rew_sum[ptw_pkg::REW_W] ^ rew_sum[ptw_pkg::REW_W-1];
  assign rew_new = clip ? (rew_sum[ptw_pkg::REW_W] ? ptw_pkg::REW_MIN : ptw_pkg::REW_MAX)
                        : rew_sum[ptw_pkg::REW_W-1:0];

  always_comb begin
    mod_node        = node;
    mod_node.reward = rew_r;
    if (op_r == ptw_pkg::OP_WRITE_SPLIT) begin
      mod_node.is_split   = 1'b1;
      mod_node.cov        = cidx_r;
      mod_node.thr        = val_r;
      mod_node.action_set = 1'b0;
    end else begin
      mod_node.is_split   = 1'b0;
      mod_node.action     = act_ok ? act_r : '0;
      mod_node.action_set = act_ok;
    end
  end

  always_comb begin
    rd_req = '0;
    wr_req = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            ptw_pkg::OP_WRITE_SPLIT, ptw_pkg::OP_WRITE_LEAF, ptw_pkg::OP_READ_REWARD: begin
              rd_req.en   = in_addr_ok;
              rd_req.addr = in_node_addr;
            end
            ptw_pkg::OP_CLASSIFY, ptw_pkg::OP_ACCUMULATE: begin
              rd_req.en   = 1'b1;
              rd_req.addr = '0;
            end
            default: ;
          endcase
        end
      end
      ST_MODIFY: begin
        wr_req.en   = 1'b1;
        wr_req.addr = addr_r;
        wr_req.data = mod_node;
      end
      ST_WALK: begin
        rd_req.en          = !walk_done;
        rd_req.addr        = child;
        wr_req.en          = (op_r == ptw_pkg::OP_ACCUMULATE);
        wr_req.addr        = n_r;
        wr_req.data        = node;
        wr_req.data.reward = rew_new;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ptw_pkg::NUM_COVARIATES; i++) begin
        cov_r[i] <= '0;
      end
    end else if (accept && (in_op == ptw_pkg::OP_LOAD_COV) && in_cidx_ok) begin
      cov_r[in_covariate_index] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      addr_r <= in_node_addr;
      cidx_r <= in_covariate_index;
      val_r  <= in_value;
      act_r  <= in_leaf_action;
      rew_r  <= in_reward_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_IDLE;
      n_r                <= '0;
      sat_r              <= 1'b0;
      out_valid_r        <= 1'b0;
      out_action_r       <= '0;
      out_action_valid_r <= 1'b0;
      out_leaf_r         <= '0;
      out_reward_r       <= '0;
      out_sat_r          <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            out_action_r       <= '0;
            out_action_valid_r <= 1'b0;
            out_leaf_r         <= '0;
            out_reward_r       <= '0;
            out_sat_r          <= 1'b0;
            n_r                <= '0;
            sat_r              <= 1'b0;
            case (in_op)
              ptw_pkg::OP_WRITE_SPLIT, ptw_pkg::OP_WRITE_LEAF: begin
                if (in_addr_ok) begin
                  state_r <= ST_MODIFY;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              ptw_pkg::OP_READ_REWARD: begin
                if (in_addr_ok) begin
                  state_r <= ST_READ;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              ptw_pkg::OP_CLASSIFY, ptw_pkg::OP_ACCUMULATE: begin
                state_r <= ST_WALK;
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        ST_MODIFY: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        ST_READ: begin
          out_valid_r  <= 1'b1;
          out_reward_r <= node.reward;
          state_r      <= ST_IDLE;
        end
        ST_WALK: begin
          if (op_r == ptw_pkg::OP_ACCUMULATE) begin
            sat_r <= sat_r | clip;
          end
          if (walk_done) begin
            out_valid_r <= 1'b1;
            out_leaf_r  <= n_r;
            if (op_r == ptw_pkg::OP_ACCUMULATE) begin
              out_sat_r <= sat_r | clip;
            end else if (node.action_set) begin
              out_action_r       <= node.action;
              out_action_valid_r <= 1'b1;
            end
            state_r <= ST_IDLE;
          end else begin
            n_r <= child;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action_out   = out_action_r;
  assign out_action_valid = out_action_valid_r;
  assign out_leaf_reached = out_leaf_r;
  assign out_reward_out   = out_reward_r;
  assign out_saturated    = out_sat_r;

endmodule
`default_nettype wire

// File: hdl/ptw_node_store.sv
// Heap-ordered node memory with a registered read and per-entry valid bits.
`default_nettype none
module ptw_node_store (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ptw_pkg::rd_req_t rd_req,
  input  wire ptw_pkg::wr_req_t wr_req,
  output ptw_pkg::node_t        rd_data
);

  ptw_pkg::node_t                     mem [ptw_pkg::NODE_COUNT];
  logic [ptw_pkg::NODE_COUNT-1:0]     valid_r;
  ptw_pkg::node_t                     rdata_r;
  logic                               rvalid_r;

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_req.data;
    end
    if (rd_req.en) begin
      rdata_r <= mem[rd_req.addr];
    end
  end

  // Entries never written since reset read as all zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (wr_req.en) begin
        valid_r[wr_req.addr] <= 1'b1;
      end
      if (rd_req.en) begin
        rvalid_r <= valid_r[rd_req.addr];
      end
    end
  end

  assign rd_data = rvalid_r ? rdata_r : '0;

endmodule
`default_nettype wire

// File: hdl/ptw_checker.sv
// Port-level checks for the policy tree walk engine, bound to the top level.
`default_nettype none
module ptw_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              out_valid,
  input wire logic                              out_action_valid,
  input wire logic [ptw_pkg::NODE_W-1:0]        out_leaf_reached,
  input wire logic signed [ptw_pkg::REW_W-1:0]  out_reward_out,
  input wire logic                              out_saturated
);

  // A result is never shown while a transaction is still in flight.
  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Every accepted transaction either starts work or reports the next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted transaction neither busy nor reported");

  // Finishing a multi-cycle transaction always delivers its result.
  a_busy_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("busy dropped without a result");

  // Classify and accumulate results never mix.
  a_action_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_action_valid && out_saturated))
    else $error("action and saturation flagged together");

  // A reward readout comes only from a read, which reports no walk position.
  a_reward_no_leaf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_reward_out != '0)) |-> (out_leaf_reached == '0))
    else $error("reward readout with a walk position");

endmodule

bind policy_tree_walk_engine ptw_checker u_ptw_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_action_valid (out_action_valid),
  .out_leaf_reached (out_leaf_reached),
  .out_reward_out   (out_reward_out),
  .out_saturated    (out_saturated)
);
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the policy tree walk engine: directed and random commands.
`timescale 1ns / 100ps

module testbench;
  import ptw_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;
  localparam logic [NODE_W-1:0] ADDR_OUT_OF_RANGE = NODE_W'(NODE_COUNT);
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] ONE_AND_HALF = 32'h0001_8000;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_GAP = 60;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS = 510;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic                    action_valid;
    logic [NODE_W-1:0]       leaf;
    logic signed [REW_W-1:0] reward;
    logic                    saturated;
  } walk_result_t;

  // Keeps a copy of the tree and covariates and the results still owed by the block.
  class walk_scoreboard;
    node_t                   nodes[NODE_COUNT];
    logic signed [VAL_W-1:0] unit_cov[NUM_COVARIATES];
    walk_result_t            pending[$];
    int unsigned             failures;

    function new();
      foreach (nodes[i]) nodes[i] = '0;
      foreach (unit_cov[i]) unit_cov[i] = '0;
      failures = 0;
    endfunction

    function void take_command(logic [OP_W-1:0] op, logic [NODE_W-1:0] addr,
                               logic [COV_W-1:0] cidx, logic signed [VAL_W-1:0] val,
                               logic [ACT_W-1:0] act, logic signed [REW_W-1:0] rew);
      walk_result_t            res;
      int unsigned             n;
      bit                      stop;
      longint                  sum;
      logic signed [VAL_W-1:0] cv;
      res = '0;
      case (op)
        OP_WRITE_SPLIT: if (addr < NODE_COUNT) begin
          nodes[addr].is_split   = 1'b1;
          nodes[addr].cov        = cidx;
          nodes[addr].thr        = val;
          nodes[addr].reward     = rew;
          nodes[addr].action_set = 1'b0;
        end
        OP_WRITE_LEAF: if (addr < NODE_COUNT) begin
          nodes[addr].is_split = 1'b0;
          nodes[addr].reward   = rew;
          if (act < NUM_ACTIONS) begin
            nodes[addr].action     = act;
            nodes[addr].action_set = 1'b1;
          end else begin
            nodes[addr].action     = '0;
            nodes[addr].action_set = 1'b0;
          end
        end
        OP_LOAD_COV: if (cidx < NUM_COVARIATES) unit_cov[cidx] = val;
        OP_CLASSIFY, OP_ACCUMULATE: begin
          n = 0;
          stop = 0;
          while (!stop) begin
            if (op == OP_ACCUMULATE) begin
              sum = longint'($signed(nodes[n].reward)) + longint'(rew);
              if (sum > longint'(REW_MAX)) begin
                sum = REW_MAX;
                res.saturated = 1'b1;
              end else if (sum < longint'(REW_MIN)) begin
                sum = REW_MIN;
                res.saturated = 1'b1;
              end
              nodes[n].reward = sum[REW_W-1:0];
            end
            // bottom-level splits end the walk like leaves
            if (!nodes[n].is_split || n >= FIRST_BOTTOM) begin
              stop = 1;
            end else begin
              cv = (nodes[n].cov < NUM_COVARIATES) ? unit_cov[nodes[n].cov] : '0;
              n = ($signed(cv) <= $signed(nodes[n].thr)) ? 2 * n + 1 : 2 * n + 2;
            end
          end
          res.leaf = NODE_W'(n);
          if (op == OP_CLASSIFY && nodes[n].action_set) begin
            res.action       = nodes[n].action;
            res.action_valid = 1'b1;
          end
        end
        OP_READ_REWARD: if (addr < NODE_COUNT) res.reward = nodes[addr].reward;
        default: ;
      endcase
      pending.push_back(res);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(walk_result_t got);
      walk_result_t want;
      if (pending.size() == 0) begin
        $error("result strobe with no transaction outstanding");
        failures++;
        return;
      end
      want = pending.pop_front();
      compare_field("action_out", want.action, got.action);
      compare_field("action_valid", want.action_valid, got.action_valid);
      compare_field("leaf_reached", want.leaf, got.leaf);
      compare_field("reward_out", longint'($signed(want.reward)),
                    longint'($signed(got.reward)));
      compare_field("saturated", want.saturated, got.saturated);
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [OP_W-1:0]         in_operation;
  logic [NODE_W-1:0]       in_node_addr;
  logic [COV_W-1:0]        in_covariate_index;
  logic signed [VAL_W-1:0] in_value;
  logic [ACT_W-1:0]        in_leaf_action;
  logic signed [REW_W-1:0] in_reward_in;
  logic                    out_valid;
  logic [ACT_W-1:0]        out_action_out;
  logic                    out_action_valid;
  logic [NODE_W-1:0]       out_leaf_reached;
  logic signed [REW_W-1:0] out_reward_out;
  logic                    out_saturated;

  walk_scoreboard board;
  int unsigned    idle_pct;
  int unsigned    quiet_cycles;

  policy_tree_walk_engine dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_node_addr      (in_node_addr),
    .in_covariate_index(in_covariate_index),
    .in_value          (in_value),
    .in_leaf_action    (in_leaf_action),
    .in_reward_in      (in_reward_in),
    .out_valid         (out_valid),
    .out_action_out    (out_action_out),
    .out_action_valid  (out_action_valid),
    .out_leaf_reached  (out_leaf_reached),
    .out_reward_out    (out_reward_out),
    .out_saturated     (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sample at the edge: inputs and outputs still hold their pre-edge values here.
  always @(posedge clk) begin
    walk_result_t got;
    if (rst_n) begin
      if (out_valid) begin
        got.action       = out_action_out;
        got.action_valid = out_action_valid;
        got.leaf         = out_leaf_reached;
        got.reward       = out_reward_out;
        got.saturated    = out_saturated;
        board.check_result(got);
      end
      if (start && !busy)
        board.take_command(in_operation, in_node_addr, in_covariate_index, in_value,
                           in_leaf_action, in_reward_in);
      if (out_valid || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Returns at the edge where the transaction is taken; start stays high for back-to-back.
  task automatic issue(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] addr,
                       input logic [COV_W-1:0] cidx, input logic signed [VAL_W-1:0] val,
                       input logic [ACT_W-1:0] act, input logic signed [REW_W-1:0] rew);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start              <= 1'b1;
    in_operation       <= op;
    in_node_addr       <= addr;
    in_covariate_index <= cidx;
    in_value           <= val;
    in_leaf_action     <= act;
    in_reward_in       <= rew;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(4))
      0: begin
        case ($urandom_range(4))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return -1;
          3: return 0;
          default: return 1;
        endcase
      end
      1: return VAL_W'($urandom_range(16)) - VAL_W'(8);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [REW_W-1:0] rand_reward();
    case ($urandom_range(9))
      0: return REW_MAX;
      1: return REW_MIN;
      2: return REW_MAX - REW_W'($urandom_range(1000));
      3: return REW_MIN + REW_W'($urandom_range(1000));
      4, 5: return REW_W'($urandom_range(2000)) - REW_W'(1000);
      default: return REW_W'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic logic [NODE_W-1:0] rand_addr();
    if ($urandom_range(49) == 0) return ADDR_OUT_OF_RANGE;
    return NODE_W'($urandom_range(NODE_COUNT - 1));
  endfunction

  // Mostly tree writes and walks; unused codes and stray addresses as noise.
  task automatic random_item();
    int unsigned       sel;
    logic [OP_W-1:0]   op;
    sel = $urandom_range(99);
    if (sel < 30) op = OP_WRITE_SPLIT;
    else if (sel < 42) op = OP_WRITE_LEAF;
    else if (sel < 57) op = OP_LOAD_COV;
    else if (sel < 75) op = OP_CLASSIFY;
    else if (sel < 90) op = OP_ACCUMULATE;
    else if (sel < 98) op = OP_READ_REWARD;
    else op = sel[0] ? OP_UNUSED_7 : OP_UNUSED_6;
    issue(op, rand_addr(), COV_W'($urandom_range(15)), rand_value(),
          ACT_W'($urandom_range(15)), rand_reward());
  endtask

  initial begin
    board = new();
    idle_pct = 16;
    quiet_cycles = 0;
    rst_n              <= 1'b0;
    start              <= 1'b0;
    in_operation       <= OP_WRITE_SPLIT;
    in_node_addr       <= '0;
    in_covariate_index <= '0;
    in_value           <= '0;
    in_leaf_action     <= '0;
    in_reward_in       <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty tree, root leaf at both reward limits
    issue(OP_READ_REWARD, 0, 0, 0, 0, 0);
    issue(OP_CLASSIFY, 0, 0, 0, 0, 0);
    issue(OP_WRITE_LEAF, 0, 0, 0, 15, REW_MAX);
    issue(OP_CLASSIFY, 0, 0, 0, 0, 0);
    issue(OP_ACCUMULATE, 0, 0, 0, 0, 1);
    issue(OP_READ_REWARD, 0, 0, 0, 0, 0);
    issue(OP_WRITE_SPLIT, 0, 15, VAL_MIN, 0, REW_MIN);
    issue(OP_ACCUMULATE, 0, 0, 0, 0, -1);
    // all-right path down to the bottom level, with a split at the bottom
    issue(OP_WRITE_SPLIT, 2, 15, VAL_MIN, 0, 0);
    issue(OP_WRITE_SPLIT, 6, 15, VAL_MIN, 0, 0);
    issue(OP_WRITE_SPLIT, 14, 15, VAL_MIN, 0, 0);
    issue(OP_WRITE_SPLIT, 30, 15, VAL_MIN, 0, 0);
    issue(OP_WRITE_SPLIT, 62, 15, VAL_MIN, 0, 0);
    issue(OP_LOAD_COV, 0, 15, VAL_MAX, 0, 0);
    issue(OP_CLASSIFY, 0, 0, 0, 0, 0);
    issue(OP_ACCUMULATE, 0, 0, 0, 0, 48'sd12345);
    issue(OP_READ_REWARD, 62, 0, 0, 0, 0);
    // covariate equal to threshold goes left
    issue(OP_WRITE_SPLIT, 14, 3, ONE_AND_HALF, 0, 0);
    issue(OP_LOAD_COV, 0, 3, ONE_AND_HALF, 0, 0);
    issue(OP_CLASSIFY, 0, 0, 0, 0, 0);
    issue(OP_WRITE_LEAF, 29, 0, 0, 0, 0);
    issue(OP_CLASSIFY, 0, 0, 0, 0, 0);
    // out-of-range node and unused codes
    issue(OP_WRITE_LEAF, ADDR_OUT_OF_RANGE, 0, 0, 5, REW_MAX);
    issue(OP_WRITE_SPLIT, ADDR_OUT_OF_RANGE, 1, 0, 0, REW_MAX);
    issue(OP_READ_REWARD, ADDR_OUT_OF_RANGE, 0, 0, 0, 0);
    issue(OP_UNUSED_6, 0, 0, 0, 0, 0);
    issue(OP_UNUSED_7, 0, 0, 0, 0, 0);

    repeat (PHASE_ITEMS) random_item();
    idle_pct = 86;
    repeat (PHASE_ITEMS) random_item();
    idle_pct = 0;
    repeat (PHASE_ITEMS) random_item();
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.failures == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
hdl/ptw_pkg.sv
hdl/ptw_node_store.sv
hdl/policy_tree_walk_engine.sv
hdl/ptw_checker.sv
test/testbench.sv
